// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes of the stable priority queue
// Entry layout, action and status codes, and the per-cycle cell command.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int IdW    = 8;
  localparam int AgeW   = 7;
  localparam int PhaseW = 3;
  localparam int ActW   = 2;
  localparam int StatW  = 2;
  localparam int ResW   = 5;

  localparam logic [ActW-1:0] ACT_ENQ  = 2'd0;
  localparam logic [ActW-1:0] ACT_DEQ  = 2'd1;
  localparam logic [ActW-1:0] ACT_FIND = 2'd2;

  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatW-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [AgeW-1:0]   age;
    logic [PhaseW-1:0] phase;
  } spq_entry_t;

  // Broadcast to every cell in the chain each cycle
  typedef struct packed {
    logic       enq;   // insert ins behind all entries of phase not larger
    logic       deq;   // shift every entry one cell towards the front
    spq_entry_t ins;   // request payload, also the id to search for
  } spq_cmd_t;

endpackage

// ===== rtl/spq_if.sv =====
// ----------------------------------------------------------------------------
// spq_if: request and response channels of the stable priority queue
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface spq_req_if;
  logic                      valid;
  logic                      ready;
  logic [spq_pkg::ActW-1:0]  action;
  logic [spq_pkg::IdW-1:0]   person_id;
  logic [spq_pkg::AgeW-1:0]  age;
  logic [spq_pkg::PhaseW-1:0] phase;

  modport source (output valid, action, person_id, age, phase, input ready);
  modport sink   (input valid, action, person_id, age, phase, output ready);
endinterface

interface spq_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [spq_pkg::StatW-1:0]  status;
  logic [spq_pkg::IdW-1:0]    out_id;
  logic [spq_pkg::AgeW-1:0]   out_age;
  logic [spq_pkg::PhaseW-1:0] out_phase;
  logic [spq_pkg::ResW-1:0]   position;
  logic [spq_pkg::ResW-1:0]   occupancy;

  modport source (output valid, status, out_id, out_age, out_phase, position, occupancy,
                  input ready);
  modport sink   (input valid, status, out_id, out_age, out_phase, position, occupancy,
                  output ready);
endinterface

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry, shifts right on insert, left on removal, flags an id match.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_pkg::spq_cmd_t   cmd_i,
  input  spq_pkg::spq_entry_t left_entry_i,
  input  logic                left_valid_i,
  input  logic                left_keep_i,
  input  spq_pkg::spq_entry_t right_entry_i,
  input  logic                right_valid_i,
  input  logic                nf_i,
  output spq_pkg::spq_entry_t entry_o,
  output logic                valid_o,
  output logic                keep_o,
  output logic                nf_o,
  output logic                first_o
);
  import spq_pkg::*;

  spq_entry_t entry_q, entry_d;
  logic       valid_q, valid_d;
  logic       match;

  // Stay put on insert when holding an entry of phase not larger
  assign keep_o  = valid_q && (entry_q.phase <= cmd_i.ins.phase);
  assign match   = valid_q && (entry_q.id == cmd_i.ins.id);
  assign first_o = nf_i & match;
  assign nf_o    = nf_i & ~match;
  assign entry_o = entry_q;
  assign valid_o = valid_q;

  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    if (cmd_i.enq) begin
      if (!keep_o) begin
        if (left_keep_i) begin
          entry_d = cmd_i.ins;
          valid_d = 1'b1;
        end else begin
          entry_d = left_entry_i;
          valid_d = left_valid_i;
        end
      end
    end else if (cmd_i.deq) begin
      entry_d = right_entry_i;
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== rtl/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded queue sorted by phase, stable within a phase
// Chain of DEPTH cells with a registered response stage.
// ----------------------------------------------------------------------------
// Each request transaction (enqueue, dequeue or find) gives exactly one response
// transaction, registered and offered in the cycle after the request is taken; a
// new request is taken every cycle while the response register is free or being
// emptied, so the sustained rate is one transaction per cycle. The entries sit
// in a row of DEPTH cells, front at cell 0. On enqueue every cell compares its
// phase with the new one at once: cells holding a phase not larger hold, the
// first other cell takes the new entry and the rest advance one cell back. A
// full queue refuses the enqueue with status full. Dequeue returns cell 0 and
// moves every entry one cell forward; an empty queue reports status empty.
// Find passes a "not yet found" flag along the row and returns the index of
// the first matching cell, or the occupancy when none matches. Every response
// carries the occupancy after the action. Position and occupancy are reported
// in 5 bits. Unknown action codes change nothing and return status ok.
module stable_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);
  import spq_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int IdxW = $clog2(DEPTH);

  // Chain wiring: index i+1 of the boundary arrays feeds cell i+1 from cell i
  spq_entry_t          cell_entry [DEPTH];
  logic [DEPTH-1:0]    cell_valid;
  logic [DEPTH-1:0]    cell_keep;
  logic [DEPTH-1:0]    cell_first;
  logic [DEPTH:0]      nf_chain;
  spq_cmd_t            cmd;

  logic [CntW-1:0]     count_q, count_d;
  logic                accept;
  logic                full, empty;
  logic                enq_go, deq_go;

  logic                rsp_valid_q;
  logic [StatW-1:0]    status_q, status_d;
  spq_entry_t          out_q, out_d;
  logic [ResW-1:0]     position_q, position_d;
  logic [ResW-1:0]     occupancy_q;

  logic [IdxW-1:0]     first_idx;
  logic [CntW-1:0]     pos_full;
  logic [CntW+ResW-1:0] pos_ext, occ_ext;

  // Take a new request whenever the response register is free or draining
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign full   = (count_q == CntW'(DEPTH));
  assign empty  = (count_q == '0);
  assign enq_go = accept && (req_i.action == ACT_ENQ) && !full;
  assign deq_go = accept && (req_i.action == ACT_DEQ) && !empty;

  assign cmd.enq       = enq_go;
  assign cmd.deq       = deq_go;
  assign cmd.ins.id    = req_i.person_id;
  assign cmd.ins.age   = req_i.age;
  assign cmd.ins.phase = req_i.phase;

  assign nf_chain[0] = 1'b1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_entry_t l_entry, r_entry;
    logic       l_valid, l_keep, r_valid;

    if (i == 0) begin : g_head
      // The front cell behaves as if a holding cell stood before it
      assign l_entry = '0;
      assign l_valid = 1'b1;
      assign l_keep  = 1'b1;
    end else begin : g_body
      assign l_entry = cell_entry[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_keep  = cell_keep[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      // Drop in an empty slot behind the last cell on dequeue
      assign r_entry = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_entry = cell_entry[i+1];
      assign r_valid = cell_valid[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .left_entry_i  (l_entry),
      .left_valid_i  (l_valid),
      .left_keep_i   (l_keep),
      .right_entry_i (r_entry),
      .right_valid_i (r_valid),
      .nf_i          (nf_chain[i]),
      .entry_o       (cell_entry[i]),
      .valid_o       (cell_valid[i]),
      .keep_o        (cell_keep[i]),
      .nf_o          (nf_chain[i+1]),
      .first_o       (cell_first[i])
    );
  end

  // At most one cell flags the first match, so OR the indices together
  always_comb begin
    first_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_first[i]) begin
        first_idx = first_idx | IdxW'(i);
      end
    end
  end

  assign pos_full = nf_chain[DEPTH] ? count_q : CntW'(first_idx);
  assign pos_ext  = {{ResW{1'b0}}, pos_full};
  assign occ_ext  = {{ResW{1'b0}}, count_d};

  always_comb begin
    count_d = count_q;
    if (enq_go) begin
      count_d = count_q + CntW'(1);
    end else if (deq_go) begin
      count_d = count_q - CntW'(1);
    end
  end

  // Build the response of this transaction
  always_comb begin
    status_d   = ST_OK;
    out_d      = '0;
    position_d = '0;
    case (req_i.action)
      ACT_ENQ: begin
        if (full) begin
          status_d = ST_FULL;
        end
      end
      ACT_DEQ: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          out_d = cell_entry[0];
        end
      end
      ACT_FIND: begin
        position_d = pos_ext[ResW-1:0];
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Hold the response payload until the next accepted request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      out_q       <= out_d;
      position_q  <= position_d;
      occupancy_q <= occ_ext[ResW-1:0];
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = status_q;
  assign rsp_o.out_id    = out_q.id;
  assign rsp_o.out_age   = out_q.age;
  assign rsp_o.out_phase = out_q.phase;
  assign rsp_o.position  = position_q;
  assign rsp_o.occupancy = occupancy_q;

endmodule

// ===== tb/stable_priority_queue_tb.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue_tb: self-checking bench of the stable priority queue
// Drives enqueue, dequeue, find and unknown-action requests in random bursts and holds a model
// of the sorted store. Every response is checked field by field, in order,
// against the predicted one while the response side stalls on its own pattern.
// ----------------------------------------------------------------------------
module stable_priority_queue_tb;
  import spq_pkg::*;

  localparam int QDEPTH      = 16;
  localparam int IDLE_LIMIT  = 2000;  // cycles without any transaction
  localparam int DRAIN_WAIT  = 10;    // settle cycles after the last response
  localparam int RANDOM_REQS = 950;

  // Action code outside the defined set: the block must leave its state alone
  localparam logic [ActW-1:0] ACT_NOP = 2'd3;

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic [IdW-1:0]    out_id;
    logic [AgeW-1:0]   out_age;
    logic [PhaseW-1:0] out_phase;
    logic [ResW-1:0]   position;
    logic [ResW-1:0]   occupancy;
  } spq_rsp_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} req_mix_e;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the sorted store and queues one expected response per
  // accepted request transaction.
  // --------------------------------------------------------------------------
  class spq_scoreboard;
    spq_entry_t model_entries [QDEPTH];
    int unsigned model_count;
    spq_rsp_t expected_rsp_q [$];
    int unsigned errors;

    function new();
      model_count = 0;
      errors      = 0;
    endfunction

    // Apply one request to the mirrored store and return its response
    function spq_rsp_t predict_response(logic [ActW-1:0] act, spq_entry_t req);
      spq_rsp_t    rsp;
      int unsigned slot;
      int unsigned k;
      rsp = '0;
      rsp.status = ST_OK;
      case (act)
        ACT_ENQ: begin
          if (model_count >= QDEPTH) begin
            rsp.status = ST_FULL;
          end else begin
            // behind every entry whose phase is not larger
            slot = 0;
            while (slot < model_count && model_entries[slot].phase <= req.phase) slot++;
            for (k = model_count; k > slot; k--) model_entries[k] = model_entries[k-1];
            model_entries[slot] = req;
            model_count++;
          end
        end
        ACT_DEQ: begin
          if (model_count == 0) begin
            rsp.status = ST_EMPTY;
          end else begin
            rsp.out_id    = model_entries[0].id;
            rsp.out_age   = model_entries[0].age;
            rsp.out_phase = model_entries[0].phase;
            for (k = 0; k + 1 < model_count; k++) model_entries[k] = model_entries[k+1];
            model_count--;
          end
        end
        ACT_FIND: begin
          slot = 0;
          while (slot < model_count && model_entries[slot].id != req.id) slot++;
          rsp.position = slot[ResW-1:0];
        end
        default: begin
        end
      endcase
      rsp.occupancy = model_count[ResW-1:0];
      return rsp;
    endfunction

    function void note_request(logic [ActW-1:0] act, spq_entry_t req);
      expected_rsp_q.push_back(predict_response(act, req));
    endfunction

    function void field_check(string name, int unsigned exp_val, int unsigned got_val);
      if (exp_val != got_val) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, got_val);
      end
    endfunction

    function void check_response(spq_rsp_t got);
      spq_rsp_t exp_rsp;
      if (expected_rsp_q.size() == 0) begin
        errors++;
        $display("%0t: response with nothing outstanding, expected none, actual %h",
                 $time, got);
      end else begin
        exp_rsp = expected_rsp_q.pop_front();
        field_check("status",    32'(exp_rsp.status),    32'(got.status));
        field_check("out_id",    32'(exp_rsp.out_id),    32'(got.out_id));
        field_check("out_age",   32'(exp_rsp.out_age),   32'(got.out_age));
        field_check("out_phase", 32'(exp_rsp.out_phase), 32'(got.out_phase));
        field_check("position",  32'(exp_rsp.position),  32'(got.position));
        field_check("occupancy", 32'(exp_rsp.occupancy), 32'(got.occupancy));
      end
    endfunction

    function int unsigned pending();
      return expected_rsp_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  spq_req_if req_if ();
  spq_rsp_if rsp_if ();

  spq_scoreboard sb = new();

  // Sender burst state, shared by every call of send_request
  int unsigned burst_left = 0;

  stable_priority_queue #(
    .DEPTH (QDEPTH)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge. Note the request first
  // so that a response in the same edge still finds its expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        sb.note_request(req_if.action,
                        '{id: req_if.person_id, age: req_if.age, phase: req_if.phase});
      end
      if (rsp_if.valid && rsp_if.ready) begin
        sb.check_response('{status:    rsp_if.status,
                            out_id:    rsp_if.out_id,
                            out_age:   rsp_if.out_age,
                            out_phase: rsp_if.out_phase,
                            position:  rsp_if.position,
                            occupancy: rsp_if.occupancy});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: count cycles without any transaction and end the run as a failure at IDLE_LIMIT.
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Response side: stall in stretches, each with a pattern of its own, so that
  // back-pressure lands on every phase of the request stream.
  // --------------------------------------------------------------------------
  initial begin : rsp_stall_gen
    stall_mode_e mode;
    int unsigned stretch;
    int unsigned period;
    int unsigned on_len;
    int unsigned k;
    rsp_if.ready = 1'b0;
    forever begin
      mode    = stall_mode_e'($urandom_range(0, 3));
      stretch = $urandom_range(20, 200);
      period  = $urandom_range(2, 12);
      on_len  = $urandom_range(1, period - 1);
      for (k = 0; k < stretch; k++) begin
        @(negedge clk_i);
        case (mode)
          STALL_NONE:     rsp_if.ready <= 1'b1;
          STALL_RANDOM:   rsp_if.ready <= 1'($urandom_range(0, 1));
          STALL_PERIODIC: rsp_if.ready <= ((k % period) < on_len);
          default:        rsp_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one request transaction; call at a falling edge, return at one.
  // Open a gap before a new burst unless the drawn gap is zero; hold valid across a burst.
  task automatic send_request(input logic [ActW-1:0] act, input spq_entry_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    req_if.valid     <= 1'b1;
    req_if.action    <= act;
    req_if.person_id <= req.id;
    req_if.age       <= req.age;
    req_if.phase     <= req.phase;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus: directed corner cases, then random traffic in fill, drain and
  // balanced stretches so the queue keeps reaching both full and empty.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [PhaseW-1:0] dir_phase [QDEPTH];
    spq_entry_t        req;
    logic [ActW-1:0]   act;
    req_mix_e          mix;
    int unsigned       mix_left;
    int unsigned       roll;
    int unsigned       i;

    dir_phase = '{3'd5, 3'd1, 3'd3, 3'd3, 3'd0, 3'd7, 3'd6, 3'd2,
                  3'd4, 3'd1, 3'd5, 3'd3, 3'd2, 3'd7, 3'd0, 3'd4};

    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.action    = ACT_ENQ;
    req_if.person_id = '0;
    req_if.age       = '0;
    req_if.phase     = '0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty queue: dequeue reports empty, find returns zero, odd action idles
    send_request(ACT_DEQ,  '{id: 8'h00, age: 7'd0, phase: 3'd1});
    send_request(ACT_FIND, '{id: 8'hA5, age: 7'd0, phase: 3'd0});
    send_request(ACT_NOP,  '{id: 8'hFF, age: 7'h7F, phase: 3'd7});

    // Fill to the brim with mixed phases including 0 and 7, repeated phases
    // and one repeated id, so find must stop at the first match
    for (i = 0; i < QDEPTH; i++) begin
      req.id    = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : (i == 9) ? 8'd26 : 8'(i * 13);
      req.age   = (i == 0) ? 7'd0 : (i == 15) ? 7'h7F : 7'(i * 8);
      req.phase = dir_phase[i];
      send_request(ACT_ENQ, req);
    end

    // Full queue refuses the entry
    send_request(ACT_ENQ,  '{id: 8'h3C, age: 7'd55, phase: 3'd1});
    send_request(ACT_FIND, '{id: 8'd26, age: 7'd0, phase: 3'd0});
    send_request(ACT_FIND, '{id: 8'hFF, age: 7'd0, phase: 3'd0});
    send_request(ACT_FIND, '{id: 8'h77, age: 7'd0, phase: 3'd0});
    send_request(ACT_DEQ,  '{id: 8'h00, age: 7'd0, phase: 3'd0});
    send_request(ACT_DEQ,  '{id: 8'h00, age: 7'd0, phase: 3'd0});

    mix      = MIX_BALANCED;
    mix_left = 0;
    for (i = 0; i < RANDOM_REQS; i++) begin
      if (mix_left == 0) begin
        mix      = req_mix_e'($urandom_range(0, 2));
        mix_left = $urandom_range(30, 80);
      end
      mix_left--;

      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        act = ACT_NOP;
      end else begin
        case (mix)
          MIX_FILL:  act = (roll < 70) ? ACT_ENQ : (roll < 85) ? ACT_DEQ : ACT_FIND;
          MIX_DRAIN: act = (roll < 23) ? ACT_ENQ : (roll < 80) ? ACT_DEQ : ACT_FIND;
          default:   act = (roll < 42) ? ACT_ENQ : (roll < 72) ? ACT_DEQ : ACT_FIND;
        endcase
      end

      // Draw ids mostly from a small pool so that finds hit and repeat
      req.id    = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 15))
                                             : 8'($urandom_range(0, 255));
      req.age   = 7'($urandom_range(0, 127));
      req.phase = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                              : 3'($urandom_range(1, 5));
      send_request(act, req);
    end
    req_if.valid <= 1'b0;

    // Drain: wait for every outstanding response, then let the block settle
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_cell.sv
rtl/stable_priority_queue.sv
tb/stable_priority_queue_tb.sv
